// File: rtl/htsc_pkg.sv
// ----------------------------------------------------------------------------
// htsc_pkg
// Shared constants for the temperature and humidity compensation pipeline:
// configuration register indexes, port widths and compensation constants.
// ----------------------------------------------------------------------------
package htsc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL_ONE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL_TWO    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL_THREE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_ONE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_TWO     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_THREE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_OFFSET_PAIR = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_CAL_SIX     = 3'd7;

	// field widths
	localparam int RAW_T_W = 20;
	localparam int RAW_H_W = 16;
	localparam int TEMP_W  = 16;
	localparam int HUMQ_W  = 17;
	localparam int HUMP_W  = 7;

	// compensation constants
	localparam logic signed [31:0] FINE_OFFSET   = 32'sd76800;
	localparam logic signed [31:0] P_ROUND       = 32'sd16384;
	localparam logic signed [31:0] R_OFFSET      = 32'sd32768;
	localparam logic signed [31:0] S_OFFSET      = 32'sd2097152;
	localparam logic signed [31:0] S_ROUND       = 32'sd8192;
	localparam logic signed [31:0] T_ROUND       = 32'sd128;
	localparam logic signed [31:0] T_SCALE       = 32'sd5;
	localparam logic signed [31:0] TEMP_MAX      = 32'sd32767;
	localparam logic signed [31:0] TEMP_MIN      = -32'sd32768;
	localparam logic signed [31:0] HUM_MAX_Q12   = 32'sd419430400;

endpackage

// File: rtl/humidity_temp_sensor_compensation.sv
// ----------------------------------------------------------------------------
// humidity_temp_sensor_compensation
// Integer temperature and humidity compensation of raw sensor readings.
// ----------------------------------------------------------------------------
// A reading pair is taken at every clock edge with start high (busy stays low,
// so a new pair may enter in every cycle). Each pair gives one result on the
// result ports once it has passed every pipeline stage, marked by result_valid for one cycle; the
// receiver cannot stall the pipeline and must take every result as it comes.
// The latency is set by the chain of dependent 32-bit multiplies, with at most
// one multiply on any path through a stage, and the sustained rate is one pair
// per cycle. Calibration words are written through the cfg port (always ready)
// and must only change while no reading is in flight.
module humidity_temp_sensor_compensation (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [htsc_pkg::RAW_T_W-1:0]          raw_temperature,
	input  logic [htsc_pkg::RAW_H_W-1:0]          raw_humidity,
	output logic                                  result_valid,
	output logic signed [htsc_pkg::TEMP_W-1:0]    temperature_centi,
	output logic [htsc_pkg::HUMQ_W-1:0]           humidity_q10,
	output logic [htsc_pkg::HUMP_W-1:0]           humidity_percent,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [htsc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [htsc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import htsc_pkg::*;

	// calibration registers
	logic [15:0] t1_q, t2_q, t3_q, h2_q;
	logic [7:0]  h1_q, h3_q, h6_q;
	logic [23:0] h45_q;

	// sign or zero extended calibration words
	logic signed [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;

	logic accept;

	// pipeline valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;

	// pipeline payload
	logic signed [31:0] d1_s1, d2_s1, ph_s1;
	logic signed [31:0] m1_s2, m2_s2, ph_s2;
	logic signed [31:0] a1_s3, m3_s3, ph_s3;
	logic signed [31:0] fine_s4, x_s4, ph_s4;
	logic signed [31:0] tw_s5, h5x_s5, q0_s5, r0_s5, ph_s5;
	logic signed [31:0] tc_s6, p_s6, q_s6, r_s6;
	logic signed [31:0] tc_s7, p_s7, m_s7;
	logic signed [31:0] tc_s8, p_s8, ms_s8;
	logic signed [31:0] tc_s9, v_s9;
	logic signed [31:0] tc_s10, v_s10, uu_s10;
	logic signed [31:0] tc_s11, v_s11, w_s11;
	logic signed [TEMP_W-1:0] tc_s12;
	logic [HUMQ_W-1:0]        hq_s12;

	// stage intermediates
	logic signed [31:0] rt_ext, rh_ext;
	logic signed [31:0] tw_r, tc_sat;
	logic signed [31:0] p_r, s_b, s2_c, u_c, v_d;
	logic [31:0]        v_clamp;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// write calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
			h3_q  <= '0;
			h45_q <= '0;
			h6_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TEMP_CAL_ONE:    t1_q  <= cfg_data[15:0];
				REG_TEMP_CAL_TWO:    t2_q  <= cfg_data[15:0];
				REG_TEMP_CAL_THREE:  t3_q  <= cfg_data[15:0];
				REG_HUM_CAL_ONE:     h1_q  <= cfg_data[7:0];
				REG_HUM_CAL_TWO:     h2_q  <= cfg_data[15:0];
				REG_HUM_CAL_THREE:   h3_q  <= cfg_data[7:0];
				REG_HUM_OFFSET_PAIR: h45_q <= cfg_data[23:0];
				REG_HUM_CAL_SIX:     h6_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// extend calibration words to 32 bits
	assign t1 = $signed({16'd0, t1_q});
	assign t2 = $signed({{16{t2_q[15]}}, t2_q});
	assign t3 = $signed({{16{t3_q[15]}}, t3_q});
	assign h1 = $signed({24'd0, h1_q});
	assign h2 = $signed({{16{h2_q[15]}}, h2_q});
	assign h3 = $signed({24'd0, h3_q});
	assign h4 = $signed({{20{h45_q[11]}}, h45_q[11:0]});
	assign h5 = $signed({{20{h45_q[23]}}, h45_q[23:12]});
	assign h6 = $signed({{24{h6_q[7]}}, h6_q});

	assign rt_ext = $signed({12'd0, raw_temperature});
	assign rh_ext = $signed({16'd0, raw_humidity});

	// round and saturate temperature, first humidity term
	always_comb begin
		tw_r = (tw_s5 + T_ROUND) >>> 8;
		if (tw_r > TEMP_MAX) begin
			tc_sat = TEMP_MAX;
		end else if (tw_r < TEMP_MIN) begin
			tc_sat = TEMP_MIN;
		end else begin
			tc_sat = tw_r;
		end
		p_r = (ph_s5 - h5x_s5 + P_ROUND) >>> 15;
	end

	// scale terms for the later humidity stages
	assign s_b  = (m_s7 >>> 10) + S_OFFSET;
	assign s2_c = (ms_s8 + S_ROUND) >>> 14;
	assign u_c  = v_s9 >>> 15;

	// subtract the square term and clamp to 0..100 percent
	always_comb begin
		v_d = v_s11 - (w_s11 >>> 4);
		if (v_d[31]) begin
			v_clamp = 32'd0;
		end else if (v_d > HUM_MAX_Q12) begin
			v_clamp = 32'(HUM_MAX_Q12);
		end else begin
			v_clamp = 32'(v_d);
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	// advance payload, at most one multiply on any path through a stage
	always_ff @(posedge clk) begin
		// differences of raw temperature and T1, shifted humidity
		d1_s1 <= (rt_ext >>> 3) - (t1 <<< 1);
		d2_s1 <= (rt_ext >>> 4) - t1;
		ph_s1 <= rh_ext <<< 14;

		m1_s2 <= d1_s1 * t2;
		m2_s2 <= d2_s1 * d2_s1;
		ph_s2 <= ph_s1 - (h4 <<< 20);

		a1_s3 <= m1_s2 >>> 11;
		m3_s3 <= (m2_s2 >>> 12) * t3;
		ph_s3 <= ph_s2;

		// fine temperature and its humidity offset
		fine_s4 <= a1_s3 + (m3_s3 >>> 14);
		x_s4    <= a1_s3 + (m3_s3 >>> 14) - FINE_OFFSET;
		ph_s4   <= ph_s3;

		tw_s5  <= fine_s4 * T_SCALE;
		h5x_s5 <= h5 * x_s4;
		q0_s5  <= x_s4 * h6;
		r0_s5  <= x_s4 * h3;
		ph_s5  <= ph_s4;

		tc_s6 <= tc_sat;
		p_s6  <= p_r;
		q_s6  <= q0_s5 >>> 10;
		r_s6  <= (r0_s5 >>> 11) + R_OFFSET;

		tc_s7 <= tc_s6;
		p_s7  <= p_s6;
		m_s7  <= q_s6 * r_s6;

		tc_s8 <= tc_s7;
		p_s8  <= p_s7;
		ms_s8 <= s_b * h2;

		tc_s9 <= tc_s8;
		v_s9  <= p_s8 * s2_c;

		tc_s10 <= tc_s9;
		v_s10  <= v_s9;
		uu_s10 <= u_c * u_c;

		tc_s11 <= tc_s10;
		v_s11  <= v_s10;
		w_s11  <= (uu_s10 >>> 7) * h1;

		// output register
		tc_s12 <= tc_s11[TEMP_W-1:0];
		hq_s12 <= v_clamp[12 +: HUMQ_W];
	end

	assign result_valid      = vld_s12;
	assign temperature_centi = tc_s12;
	assign humidity_q10      = hq_s12;
	assign humidity_percent  = hq_s12[HUMQ_W-1 -: HUMP_W];

	// result strobe follows the last valid stage
	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s12 |-> $past(vld_s11))
		else $error("result strobe without a valid item in the last stage");

	// clamped humidity stays within 100 percent
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (humidity_q10 <= 17'd102400))
		else $error("humidity above full scale");

	// whole percent stays within 100
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (humidity_percent <= 7'd100))
		else $error("whole percent above 100");

	// an accepted request reaches the second stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 vld_s2)
		else $error("accepted request lost in the first stages");

endmodule
